>>> sv/spvx_pkg.sv
// Package for the SPIR-V entry point extractor.
// It holds the channel item types, the job record between the front and back parts, and constants.
// It depends on nothing else.
`default_nettype none

package spvx_pkg;

   localparam logic [31:0] SPV_MAGIC       = 32'h0723_0203;
   localparam logic [15:0] OP_ENTRY_POINT  = 16'd15;
   localparam logic [15:0] MIN_ENTRY_WORDS = 16'd4;
   localparam logic [2:0]  HEADER_WORDS    = 3'd5;

   typedef enum logic [1:0] {
      KIND_ENTRY = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_OK    = 2'd2,
      KIND_FAIL  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [31:0] code_word;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] payload;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        has_model;
      logic [2:0]  char_count;
      logic        has_report;
      logic        report_fail;
      logic [31:0] data;
   } job_type;

endpackage

`default_nettype wire

>>> sv/spvx_front.sv
// Front part of the SPIR-V entry point extractor.
// It accepts code words, tracks header and instruction position, and builds a job per word with result items.
// It depends on spvx_pkg.
`default_nettype none

module spvx_front
   import spvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   input  logic    queue_full,
   output logic    job_push,
   output job_type job
);

   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [15:0] words_left_ff, words_left_in;
   logic [1:0]  word_idx_ff, word_idx_in;
   logic        collecting_ff, collecting_in;
   logic        name_done_ff, name_done_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic [15:0] count;
   logic [15:0] opcode;
   logic [3:0]  zero_byte;
   logic [2:0]  name_len;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign count     = req.code_word[31:16];
   assign opcode    = req.code_word[15:0];

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         zero_byte[b] = (req.code_word[8*b +: 8] == 8'd0);
      end
      if (zero_byte[0]) begin
         name_len = 3'd0;
      end else if (zero_byte[1]) begin
         name_len = 3'd1;
      end else if (zero_byte[2]) begin
         name_len = 3'd2;
      end else if (zero_byte[3]) begin
         name_len = 3'd3;
      end else begin
         name_len = 3'd4;
      end
   end

   always_comb begin
      hdr_pos_in    = hdr_pos_ff;
      words_left_in = words_left_ff;
      word_idx_in   = word_idx_ff;
      collecting_in = collecting_ff;
      name_done_in  = name_done_ff;
      failed_in     = failed_ff;
      job           = '0;
      job.data      = req.code_word;

      if (!failed_ff) begin
         if (hdr_pos_ff < HEADER_WORDS) begin
            if (hdr_pos_ff == 3'd0 && req.code_word != SPV_MAGIC) begin
               failed_in       = 1'b1;
               job.has_report  = 1'b1;
               job.report_fail = 1'b1;
            end else begin
               hdr_pos_in = hdr_pos_ff + 3'd1;
            end
         end else if (words_left_ff == 16'd0) begin
            if (count == 16'd0) begin
               failed_in       = 1'b1;
               job.has_report  = 1'b1;
               job.report_fail = 1'b1;
            end else begin
               words_left_in = count - 16'd1;
               word_idx_in   = 2'd1;
               collecting_in = (opcode == OP_ENTRY_POINT) && (count >= MIN_ENTRY_WORDS);
               name_done_in  = 1'b0;
            end
         end else begin
            if (collecting_ff) begin
               if (word_idx_ff == 2'd1) begin
                  job.has_model = 1'b1;
               end else if (word_idx_ff == 2'd3 && !name_done_ff) begin
                  job.char_count = name_len;
                  name_done_in   = (name_len != 3'd4);
               end
            end
            words_left_in = words_left_ff - 16'd1;
            if (word_idx_ff != 2'd3) begin
               word_idx_in = word_idx_ff + 2'd1;
            end
            if (words_left_in == 16'd0) begin
               collecting_in = 1'b0;
            end
         end
      end

      if (req.final_word) begin
         if (!failed_ff && !failed_in) begin
            job.has_report  = 1'b1;
            job.report_fail = (hdr_pos_in < HEADER_WORDS) || (words_left_in != 16'd0);
         end
         hdr_pos_in    = 3'd0;
         words_left_in = 16'd0;
         word_idx_in   = 2'd0;
         collecting_in = 1'b0;
         name_done_in  = 1'b0;
         failed_in     = 1'b0;
      end

      job_push = accept && (job.has_model || job.char_count != 3'd0 || job.has_report);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff    <= 3'd0;
         words_left_ff <= 16'd0;
         word_idx_ff   <= 2'd0;
         collecting_ff <= 1'b0;
         name_done_ff  <= 1'b0;
         failed_ff     <= 1'b0;
      end else if (accept) begin
         hdr_pos_ff    <= hdr_pos_in;
         words_left_ff <= words_left_in;
         word_idx_ff   <= word_idx_in;
         collecting_ff <= collecting_in;
         name_done_ff  <= name_done_in;
         failed_ff     <= failed_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/spvx_queue.sv
// Job queue between the front and back parts of the entry point extractor.
// It is a small first-in first-out register file of job records.
// It depends on spvx_pkg.
`default_nettype none

module spvx_queue
   import spvx_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/spvx_back.sv
// Back part of the SPIR-V entry point extractor.
// It takes job records from the queue and sends their result items one per cycle while rsp_stall is low.
// It depends on spvx_pkg.
`default_nettype none

module spvx_back
   import spvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  job_type queue_data,
   output logic    queue_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   job_type    job_ff;
   logic       job_valid_ff;
   logic [2:0] pos_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff;

   logic       out_free;
   logic       advance;
   logic       last_item;
   logic [2:0] total;
   logic [2:0] char_idx;
   logic       load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      total     = {2'b00, job_ff.has_model} + job_ff.char_count + {2'b00, job_ff.has_report};
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = job_valid_ff && out_free;
      last_item = (pos_ff == total - 3'd1);
      char_idx  = pos_ff - {2'b00, job_ff.has_model};
      load      = (!job_valid_ff || (advance && last_item)) && !queue_empty;
      queue_pop = load;

      rsp_in.last_of_run = last_item;
      if (job_ff.has_model && pos_ff == 3'd0) begin
         rsp_in.kind    = KIND_ENTRY;
         rsp_in.payload = job_ff.data;
      end else if (char_idx < job_ff.char_count) begin
         rsp_in.kind    = KIND_CHAR;
         rsp_in.payload = {24'd0, job_ff.data[8*char_idx[1:0] +: 8]};
      end else begin
         rsp_in.kind    = job_ff.report_fail ? KIND_FAIL : KIND_OK;
         rsp_in.payload = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= queue_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            job_valid_ff <= 1'b1;
            pos_ff       <= 3'd0;
         end else if (advance && last_item) begin
            job_valid_ff <= 1'b0;
         end else if (advance) begin
            pos_ff <= pos_ff + 3'd1;
         end
         if (out_free) begin
            rsp_valid_ff <= advance;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/spirv_entry_point_extractor_top.sv
// Top level of the SPIR-V entry point extractor.
// It joins the front part, the job queue and the back part.
// It depends on spvx_pkg, spvx_front, spvx_queue and spvx_back.
//
//   Channel   Direction   Handshake             Item
//   req       in          req_valid/req_stall   req_type: code_word, final_word
//   rsp       out         rsp_valid/rsp_stall   rsp_type: kind, payload, last_of_run
//
// The front part takes one word per cycle while the job queue has room.
// The back part sends one result item per cycle while rsp_stall is low; a word causes up to
// five items, and a name word with four characters causes four character items.
// Reset is synchronous and returns the block to the start of a module.
// A stall on rsp fills the queue of QUEUE_DEPTH jobs, and then req_stall rises.
`default_nettype none

module spirv_entry_point_extractor_top
   import spvx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    queue_full;
   logic    queue_empty;
   logic    job_push;
   logic    queue_pop;
   job_type front_job;
   job_type queue_job;

   spvx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job        (front_job)
   );

   spvx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_job),
      .empty     (queue_empty)
   );

   spvx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_job),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   // An item that is not the last of its word is always followed by another one.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.last_of_run |=> rsp_valid)
      else $error("result run broken before its last item");

   // A success or failure report always closes the run of its word.
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == KIND_OK || rsp.kind == KIND_FAIL) |-> rsp.last_of_run)
      else $error("report item is not the last of its run");

   // The queue cannot be full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(queue_full && queue_empty))
      else $error("job queue full and empty together");

endmodule

`default_nettype wire
